// ----- design/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial vector and the round and schedule functions.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned NumRounds = 64;

  typedef logic [31:0] word_t;

  typedef enum logic [0:0] {
    FUNC_DATA = 1'b0,
    FUNC_END  = 1'b1
  } func_e;

  // One queue entry between the front and the back: one padded byte.
  typedef struct packed {
    logic [7:0] data;
    logic       finish;
  } byte_cmd_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_vec(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

// ----- design/sha_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts items, counts message bits and expands an end item into padding.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_front import sha_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  output logic           full_o,
  input  wire logic      func_i,
  input  wire logic [7:0] data_byte_i,
  output logic           cmd_valid_o,
  input  wire logic      cmd_ready_i,
  output byte_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ZERO = 4'b0010,
    ST_LEN  = 4'b0100,
    ST_HOLD = 4'b1000
  } fstate_e;

  fstate_e     state_q, state_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q, len_d;
  logic [5:0]  fill_q, fill_d;   // bytes sent mod 64
  logic [2:0]  lcnt_q, lcnt_d;
  byte_cmd_t   hold_q, hold_d;   // pending byte when queue is full
  logic        fire;
  // marks that the held byte is a padding marker
  logic        len_pending_q, len_pending_d;

  assign full_o = (state_q != ST_IDLE);
  assign fire   = push_i && !full_o;

  always_comb begin
    state_d = state_q;
    bits_d  = bits_q;
    len_d   = len_q;
    fill_d  = fill_q;
    lcnt_d  = lcnt_q;
    hold_d  = hold_q;
    cmd_valid_o = 1'b0;
    cmd_o   = hold_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          cmd_o.finish = 1'b0;
          cmd_o.data   = (func_i == FUNC_END) ? 8'h80 : data_byte_i;
          cmd_valid_o  = 1'b1;
          if (func_i == FUNC_END) begin
            len_d  = bits_q;
            bits_d = '0;
            lcnt_d = '0;
          end else begin
            bits_d = bits_q + 64'd8;
          end
          if (!cmd_ready_i) begin
            hold_d  = cmd_o;
            state_d = ST_HOLD;
          end else begin
            fill_d = fill_q + 6'd1;
            if (func_i == FUNC_END) state_d = ST_ZERO;
          end
        end
      end
      ST_HOLD: begin
        cmd_valid_o = 1'b1;
        cmd_o = hold_q;
        if (cmd_ready_i) begin
          fill_d = fill_q + 6'd1;
          // padding marker was held: continue padding
          state_d = (hold_q.data == 8'h80 && bits_q == '0 && lcnt_q == '0 &&
                     len_pending_q) ? ST_ZERO : ST_IDLE;
        end
      end
      ST_ZERO: begin
        cmd_valid_o = (fill_q != 6'd56);
        cmd_o.data = 8'h00;
        cmd_o.finish = 1'b0;
        if (fill_q == 6'd56) state_d = ST_LEN;
        else if (cmd_ready_i) fill_d = fill_q + 6'd1;
      end
      default: begin
        cmd_valid_o  = 1'b1;
        cmd_o.data   = len_q[63:56];
        cmd_o.finish = (lcnt_q == 3'd7);
        if (cmd_ready_i) begin
          len_d  = {len_q[55:0], 8'h00};
          lcnt_d = lcnt_q + 3'd1;
          fill_d = fill_q + 6'd1;
          if (lcnt_q == 3'd7) state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    len_pending_d = len_pending_q;
    if (state_q == ST_IDLE && fire) len_pending_d = (func_i == FUNC_END);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bits_q  <= '0;
      fill_q  <= '0;
      lcnt_q  <= '0;
      len_pending_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bits_q  <= bits_d;
      fill_q  <= fill_d;
      lcnt_q  <= lcnt_d;
      len_pending_q <= len_pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    hold_q <= hold_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEN) |-> (fill_q >= 6'd56))
    else $error("length bytes out of place");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && cmd_o.finish) |-> (fill_q == 6'd63))
    else $error("finish not at block end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ZERO) |-> (bits_q == '0))
    else $error("bit count not cleared");

endmodule
`default_nettype wire

// ----- design/sha_fifo.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte queue
// Short queue of padded bytes between front end and compression core.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_fifo import sha_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_valid_i,
  output logic       wr_ready_o,
  input  byte_cmd_t  wr_data_i,
  output logic       rd_valid_o,
  input  wire logic  rd_ready_i,
  output byte_cmd_t  rd_data_o
);

  byte_cmd_t  mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 3'd4);
  assign rd_valid_o = (cnt_q != 3'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b00, wr} - {2'b00, rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd0) |-> (wp_q == rp_q)) else $error("pointers out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd4) |-> (wp_q == rp_q)) else $error("pointers out of step");

endmodule
`default_nettype wire

// ----- design/sha_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Packs bytes into a block, runs 64 rounds, keeps the hash, emits the digest.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_core import sha_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  byte_cmd_t   in_i,
  output logic        empty_o,
  input  wire logic   pop_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [3:0] {
    ST_FILL  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_OUT   = 4'b1000
  } cstate_e;

  cstate_e     state_q;
  word_t       w_q [16];     // schedule window, w_q[0] is current
  word_t       h_q [8];
  word_t       v_q [8];
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        fin_q;

  word_t w_cur, w_new, t1, t2, maj, ch;

  assign in_ready_o = (state_q == ST_FILL);
  assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
  assign w_cur = w_q[0];
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + bsig1(v_q[4]) + ch + round_k(rnd_q) + w_cur;
  assign t2  = bsig0(v_q[0]) + maj;

  assign empty_o       = (state_q != ST_OUT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL && in_valid_i) begin
      w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], in_i.data};
      if (fill_q == 6'd63) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fill_q  <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      fin_q   <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_vec(3'(i));
    end else begin
      unique case (state_q)
        ST_FILL: if (in_valid_i) begin
          fill_q <= fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            fin_q   <= in_i.finish;
            rnd_q   <= '0;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          oidx_q  <= '0;
          state_q <= fin_q ? ST_OUT : ST_FILL;
        end
        default: if (pop_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= init_vec(3'(i));
            state_q <= ST_FILL;
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_ADD))
    else $error("round count lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (fill_q == 6'd0)) else $error("digest mid block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FILL) |-> !in_ready_o) else $error("accept while busy");

endmodule
`default_nettype wire

// ----- design/sha256_byte_stream_hasher_top.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream; an end item pads the message and returns the digest.
// ----------------------------------------------------------------------------
//  channel | handshake    | payload
//  input   | push / full  | func_i, data_byte_i
//  result  | pop / empty  | digest_word_o, word_index_o, last_word_o
//
// The front passes a data byte on when the queue has room; bytes wait in a
// four-entry queue. The queue stalls while the compression core runs the
// rounds and final add of each 64-byte block, as the core takes no byte then.
// An end item keeps full high until all padding bytes have been queued.
// Digest words stay until popped; the core takes no byte meanwhile.
// Reset loads the initial vector and clears all counters.
`default_nettype none
module sha256_byte_stream_hasher_top import sha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        func_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  byte_cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  sha_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .func_i, .data_byte_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  sha_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_cmd)
  );

  sha_core u_core (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .in_ready_o(q_ready), .in_i(q_cmd),
    .empty_o(empty), .pop_i(pop), .digest_word_o, .word_index_o, .last_word_o
  );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Streams directed and random messages into the hasher, computes
// each digest with a local SHA-256 model and checks every digest word.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import sha_pkg::*;

  typedef struct packed {
    func_e      func;
    logic [7:0] data;
  } hash_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_out_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk_i, rst_ni;
  logic        push, full, func_i, empty, pop, last_word_o;
  logic [7:0]  data_byte_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;

  sha256_byte_stream_hasher_top u_top (
    .clk_i, .rst_ni, .push, .full, .func_i, .data_byte_i,
    .empty, .pop, .digest_word_o, .word_index_o, .last_word_o
  );

  hash_item_t  pending_items[$];
  digest_out_t digest_words_due[$];
  int          error_count = 0;
  bit          stim_done = 0;
  int          drain_hold = -1;  // item index at which to wait for an empty scoreboard

  // Local hasher state
  logic [31:0] hw [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] msg_bits;

  function automatic logic [31:0] rr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int k = 0; k < 8; k++) v[k] = hw[k];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int k = 7; k > 0; k--) v[k] = v[k-1];
      v[4] += t1;
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) hw[k] += v[k];
  endtask

  task automatic absorb_byte(logic [7:0] b);
    blk[fill] = b;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic predict_digest(hash_item_t it);
    logic [63:0] len;
    if (it.func == FUNC_DATA) begin
      absorb_byte(it.data);
      msg_bits += 64'd8;
    end else begin
      len = msg_bits;
      absorb_byte(8'h80);
      while (fill != 56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[8*(7-i) +: 8]);
      for (int i = 0; i < 8; i++)
        digest_words_due.push_back('{hw[i], 3'(i), i == 7});
      for (int k = 0; k < 8; k++) hw[k] = IV_TAB[k];
      msg_bits = '0;
    end
  endtask

  task automatic add_message(int len, int mode);
    for (int i = 0; i < len; i++)
      pending_items.push_back('{FUNC_DATA,
        mode == 0 ? 8'($urandom) : (mode == 1 ? 8'h00 : 8'hff)});
    pending_items.push_back('{FUNC_END, 8'($urandom)});
  endtask

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  int n_lens[6] = '{55, 56, 63, 64, 65, 119};

  // Stimulus: empty message, "abc", single-byte messages, padding boundaries, then random messages
  initial begin
    for (int k = 0; k < 8; k++) hw[k] = IV_TAB[k];
    fill = 0;
    msg_bits = '0;
    add_message(0, 0);
    pending_items.push_back('{FUNC_DATA, 8'h61});
    pending_items.push_back('{FUNC_DATA, 8'h62});
    pending_items.push_back('{FUNC_DATA, 8'h63});
    pending_items.push_back('{FUNC_END, 8'hff});
    add_message(1, 1);
    add_message(1, 2);
    add_message(0, 0);
    foreach (n_lens[i]) add_message(n_lens[i], $urandom_range(0, 2));
    drain_hold = pending_items.size();
    while (pending_items.size() < 460) begin
      if ($urandom_range(0, 9) == 0) add_message($urandom_range(21, 40), 0);
      else add_message($urandom_range(0, 20), 0);
    end
  end

  // Driver
  int   sent = 0, gap = 0, burst = 0;
  logic in_fire;
  assign in_fire = push && !full;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      func_i <= 1'b0;
      data_byte_i <= '0;
    end else begin
      if (in_fire) begin
        predict_digest(pending_items.pop_front());
        sent++;
      end
      if (push && !in_fire) begin
        // hold the item until accepted
      end else if (pending_items.size() == 0) begin
        push <= 1'b0;
        stim_done <= 1'b1;
      end else if (sent == drain_hold && digest_words_due.size() != 0) begin
        push <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        {func_i, data_byte_i} <= pending_items[0];
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
        end else burst--;
      end
    end
  end

  // Monitor
  int stall_ctr = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    digest_out_t exp_w;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (digest_words_due.size() == 0) begin
          $display("%0t unexpected digest word: expected none, actual %h",
                   $time, digest_word_o);
          error_count++;
        end else begin
          exp_w = digest_words_due.pop_front();
          if (digest_word_o !== exp_w.word || word_index_o !== exp_w.index ||
              last_word_o !== exp_w.last) begin
            $display("%0t digest mismatch: expected %h/%0d/%b, actual %h/%0d/%b", $time,
                     exp_w.word, exp_w.index, exp_w.last,
                     digest_word_o, word_index_o, last_word_o);
            error_count++;
          end
        end
      end
      stall_ctr++;
      pop <= (stall_ctr % 512) < 256 ? 1'b1 : (($urandom_range(0, 3) != 0));
    end
  end

  initial begin
    wait (stim_done);
    wait (digest_words_due.size() == 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && digest_words_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
